// ----- rtl/core/ktt_pkg.sv -----
package ktt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int ANCHOR_SLOTS_DEF  = 4;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 3;
    localparam int OUT_W   = 3;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0] MIN_ANCHORS_RESET = 3'd3;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic             ready_res;
        logic [OUT_W-1:0] count;
        logic             stored;
        logic             created;
        logic             found;
        logic [OUT_W-1:0] slot;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

// ----- rtl/core/ktt_ram.sv -----
module ktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/keyed_timestamp_table_oldest_replace_core.sv -----
// One transaction at a time: s_axis_tready is high only while idle, so a new transaction is
// taken once the last result is in the output register; the entry memory has one
// read port and the key match and oldest-stamp search walk it one entry per cycle.
// Reset: rst_n asynchronous, active low; all valid bits clear at once (table empty,
// no clearing pass), min_anchors returns to 3, the output register empties.
module keyed_timestamp_table_oldest_replace_core #(
    parameter int TABLE_ENTRIES = ktt_pkg::TABLE_ENTRIES_DEF,
    parameter int ANCHOR_SLOTS  = ktt_pkg::ANCHOR_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ktt_pkg::CFG_W-1:0]     cfg_data,     // min_anchors
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // node_key[63:0], rx_time[95:64], now_ms[127:96]
    input  logic [ktt_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command[0], packet_valid[1]
    input  logic [ktt_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // slot[2:0], found[3], created[4], stored[5], count[8:6], ready_res[9], zero[15:10]
    output logic [ktt_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import ktt_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(ANCHOR_SLOTS + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int RT_D    = TABLE_ENTRIES * ANCHOR_SLOTS;
    localparam int RT_AW   = $clog2(RT_D);
    localparam int ENT_W   = KEY_W + CNT_W + TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ANCHOR_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         min_anchors_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic                     cmd_reg;
    logic                     pv_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [TIME_W-1:0]        rx_reg;
    logic [TIME_W-1:0]        now_reg;

    logic [IDX_W-1:0]         scan_reg;
    logic                     pend_reg;
    logic [IDX_W-1:0]         pend_idx_reg;

    logic                     match_reg;
    logic [IDX_W-1:0]         match_idx_reg;
    logic [CNT_W-1:0]         match_cnt_reg;
    logic [TIME_W-1:0]        min_stamp_reg;
    logic [IDX_W-1:0]         min_idx_reg;

    res_t                     res_reg, res_next;
    logic                     out_valid_reg;
    res_t                     out_reg;

    logic                     ent_re, ent_we;
    logic [ENT_W-1:0]         ent_rdata, ent_wdata;
    logic [IDX_W-1:0]         sel_idx;
    logic [CNT_W-1:0]         base_cnt, new_cnt;
    logic                     is_rec, is_query, do_store;
    logic [RT_AW-1:0]         rt_addr;

    logic                     rd_valid;
    logic [KEY_W-1:0]         rd_key;
    logic [CNT_W-1:0]         rd_cnt;
    logic [TIME_W-1:0]        rd_stamp;
    logic                     rd_match;
    logic                     out_free;

    ktt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (sel_idx),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (scan_reg),
        .rdata (ent_rdata)
    );

    ktt_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RT_D)
    ) u_rxtime_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (rt_addr),
        .wdata (rx_reg),
        .re    (1'b0),
        .raddr (rt_addr),
        .rdata ()
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_reg);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign ent_re = (state_reg == S_SCAN);

    // invalid entries read as reset value
    assign rd_valid = valid_reg[pend_idx_reg];
    assign rd_key   = rd_valid ? ent_rdata[ENT_W-1 -: KEY_W] : '0;
    assign rd_cnt   = rd_valid ? ent_rdata[TIME_W +: CNT_W] : '0;
    assign rd_stamp = rd_valid ? ent_rdata[TIME_W-1:0] : '0;
    assign rd_match = rd_valid && (rd_key == key_reg);

    always_comb
    begin
        is_query = (cmd_reg == CMD_QUERY);
        is_rec   = (cmd_reg == CMD_RECORD) && pv_reg;
        sel_idx  = match_reg ? match_idx_reg : min_idx_reg;
        base_cnt = match_reg ? match_cnt_reg : '0;
        do_store = is_rec && (base_cnt < FULL_CNT);
        new_cnt  = do_store ? (base_cnt + CNT_W'(1)) : base_cnt;
        ent_we   = (state_reg == S_WRITE) && do_store;
        ent_wdata = {key_reg, new_cnt, now_reg};
        rt_addr  = RT_AW'(RT_AW'(sel_idx) * RT_AW'(ANCHOR_SLOTS)) + RT_AW'(base_cnt);

        res_next = '0;
        if (is_query)
        begin
            if (match_reg)
            begin
                res_next.found     = 1'b1;
                res_next.slot      = OUT_W'(match_idx_reg);
                res_next.count     = OUT_W'(match_cnt_reg);
                res_next.ready_res = (CMP_W'(match_cnt_reg) >= CMP_W'(min_anchors_reg));
            end
        end
        else if (is_rec)
        begin
            res_next.slot    = OUT_W'(sel_idx);
            res_next.found   = match_reg;
            res_next.created = !match_reg;
            res_next.stored  = do_store;
            res_next.count   = OUT_W'(new_cnt);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            min_anchors_reg <= MIN_ANCHORS_RESET;
            valid_reg       <= '0;
            scan_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                min_anchors_reg <= cfg_data;
            end
            if (state_reg == S_IDLE)
            begin
                scan_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            pend_reg <= (state_reg == S_SCAN);
            if (ent_we)
            begin
                valid_reg[sel_idx] <= 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= s_axis_tuser[0];
            pv_reg    <= s_axis_tuser[1];
            key_reg   <= s_axis_tdata[KEY_W-1:0];
            rx_reg    <= s_axis_tdata[KEY_W +: TIME_W];
            now_reg   <= s_axis_tdata[KEY_W+TIME_W +: TIME_W];
            match_reg <= 1'b0;
        end
        pend_idx_reg <= scan_reg;
        if (pend_reg)
        begin
            if (!match_reg && rd_match)
            begin
                match_reg     <= 1'b1;
                match_idx_reg <= pend_idx_reg;
                match_cnt_reg <= rd_cnt;
            end
            if (pend_idx_reg == '0 || rd_stamp < min_stamp_reg)
            begin
                min_stamp_reg <= rd_stamp;
                min_idx_reg   <= pend_idx_reg;
            end
        end
        if (state_reg == S_WRITE)
        begin
            res_reg <= res_next;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    a_ent_we_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        ent_we |-> (state_reg == S_WRITE))
        else $error("entry write outside write step");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(valid_reg) & ~valid_reg) == '0))
        else $error("entry valid bit cleared");

    a_stored_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.stored) |-> (out_reg.count != '0 && !out_reg.ready_res))
        else $error("stored result with bad count or ready");

    a_ready_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.ready_res) |-> out_reg.found)
        else $error("ready reported without a hit");
`endif

endmodule

// ----- tb/keyed_timestamp_table_oldest_replace_core_tb.sv -----
module keyed_timestamp_table_oldest_replace_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ktt_pkg::*;

    localparam int NENT      = TABLE_ENTRIES_DEF;
    localparam int NSLOT     = ANCHOR_SLOTS_DEF;
    localparam int POOL_SZ   = 10;
    localparam int PHASES    = 9;
    localparam int PHASE_LEN = 98;
    localparam int STALL_LEN = 300;
    localparam int LIMIT     = 200000;

    typedef struct {
        logic              cmd;
        logic              pkt_ok;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] rx;
        logic [TIME_W-1:0] now;
    } packet_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // node_key, rx_time, now_ms
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // command, packet_valid
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // slot, found, created, stored, count, ready_res

    // predicted table contents
    logic [KEY_W-1:0]  tbl_key   [NENT];
    logic              tbl_valid [NENT];
    int                tbl_count [NENT];
    logic [TIME_W-1:0] tbl_stamp [NENT];
    logic [CFG_W-1:0]  tbl_min;

    packet_t           packet_q[$];
    res_t              report_q[$];
    packet_t           on_bus;
    logic [KEY_W-1:0]  key_pool [POOL_SZ];
    logic [TIME_W-1:0] clock_ms;
    logic              burst_mode = 1'b0;
    logic              stall_armed = 1'b0;
    logic              sink_stall = 1'b0;
    int                err_cnt = 0;
    int                cycles = 0;

    keyed_timestamp_table_oldest_replace_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        err_cnt++;
    endtask

    // lookup, oldest-stamp claim and append, as the table does it
    function automatic res_t table_step(input packet_t p);
        res_t r;
        int   hit;
        int   pick;
        r   = '0;
        hit = -1;
        for (int i = 0; i < NENT; i++)
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == p.key)
                hit = i;
        if (p.cmd == CMD_QUERY)
        begin
            if (hit >= 0)
            begin
                r.slot      = hit[OUT_W-1:0];
                r.found     = 1'b1;
                r.count     = tbl_count[hit][OUT_W-1:0];
                r.ready_res = (tbl_count[hit] >= int'(tbl_min));
            end
        end
        else if (p.pkt_ok)
        begin
            pick = hit;
            if (hit >= 0)
                r.found = 1'b1;
            else
            begin
                pick = 0;
                for (int i = 1; i < NENT; i++)
                    if (tbl_stamp[i] < tbl_stamp[pick])
                        pick = i;
                tbl_key[pick]   = p.key;
                tbl_valid[pick] = 1'b1;
                tbl_count[pick] = 0;
                tbl_stamp[pick] = p.now;
                r.created       = 1'b1;
            end
            if (tbl_count[pick] < NSLOT)
            begin
                tbl_count[pick]++;
                tbl_stamp[pick] = p.now;
                r.stored        = 1'b1;
            end
            r.slot  = pick[OUT_W-1:0];
            r.count = tbl_count[pick][OUT_W-1:0];
        end
        return r;
    endfunction

    // source side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                report_q.push_back(table_step(on_bus));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (packet_q.size() != 0 && (burst_mode || $urandom_range(0, 99) >= 28))
                begin
                    on_bus = packet_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {on_bus.now, on_bus.rx, on_bus.key};
                    s_axis_tuser  <= {on_bus.pkt_ok, on_bus.cmd};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side and checking
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = res_t'(m_axis_tdata[RES_W-1:0]);
                if (report_q.size() == 0)
                    note_mismatch($sformatf("result with none expected: %h", m_axis_tdata));
                else
                begin
                    want = report_q.pop_front();
                    if (got.slot != want.slot)
                        note_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
                    if (got.found != want.found)
                        note_mismatch($sformatf("found %b, want %b", got.found, want.found));
                    if (got.created != want.created)
                        note_mismatch($sformatf("created %b, want %b",
                                                got.created, want.created));
                    if (got.stored != want.stored)
                        note_mismatch($sformatf("stored %b, want %b", got.stored, want.stored));
                    if (got.count != want.count)
                        note_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
                    if (got.ready_res != want.ready_res)
                        note_mismatch($sformatf("ready_res %b, want %b",
                                                got.ready_res, want.ready_res));
                    if (m_axis_tdata[M_TDATA_W-1:RES_W] != '0)
                        note_mismatch($sformatf("padding not zero: %h", m_axis_tdata));
                end
            end
            m_axis_tready <= !sink_stall && (burst_mode || $urandom_range(0, 99) >= 28);
        end
    end

    // long back-pressure on the result side
    initial
    begin
        wait (stall_armed);
        @(posedge clk);
        sink_stall <= 1'b1;
        repeat (STALL_LEN) @(posedge clk);
        sink_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_packet(input logic cmd, input logic ok, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] rx, input logic [TIME_W-1:0] now);
        packet_t p;
        p.cmd    = cmd;
        p.pkt_ok = ok;
        p.key    = key;
        p.rx     = rx;
        p.now    = now;
        packet_q.push_back(p);
    endtask

    task automatic queue_random_packet();
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        int                r;
        int                idx;
        r = $urandom_range(0, 99);
        if (r < 72)
            key = key_pool[$urandom_range(0, POOL_SZ - 1)];
        else if (r < 84)
            key = {$urandom, $urandom};
        else if (r < 89)
            key = '0;
        else if (r < 94)
            key = '1;
        else
        begin
            idx = $urandom_range(0, POOL_SZ - 1);
            key_pool[idx] = {$urandom, $urandom};
            key = key_pool[idx];
        end
        r = $urandom_range(0, 99);
        if (r < 6)
            now = $urandom;
        else if (r < 8)
            now = '0;
        else if (r < 10)
            now = '1;
        else
        begin
            clock_ms = clock_ms + $urandom_range(0, 3);
            now = clock_ms;
        end
        queue_packet(($urandom_range(0, 99) < 30) ? CMD_QUERY : CMD_RECORD,
                     $urandom_range(0, 99) >= 10, key, $urandom, now);
    endtask

    task automatic program_min(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_min = v;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (packet_q.size() != 0 || s_axis_tvalid || report_q.size() != 0);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_min [PHASES];
        phase_min = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6, 3'd3, 3'd4};
        for (int i = 0; i < NENT; i++)
        begin
            tbl_key[i]   = '0;
            tbl_valid[i] = 1'b0;
            tbl_count[i] = 0;
            tbl_stamp[i] = '0;
        end
        tbl_min  = MIN_ANCHORS_RESET;
        clock_ms = 32'd100;
        for (int i = 0; i < POOL_SZ; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        queue_packet(CMD_QUERY,  1'b1, '0, '0, '0);          // empty table
        queue_packet(CMD_RECORD, 1'b0, '1, '1, '1);          // invalid packet
        queue_packet(CMD_RECORD, 1'b1, '0, '0, 32'd5);
        queue_packet(CMD_QUERY,  1'b0, '0, '0, '0);
        for (int i = 0; i < 5; i++)                          // fill past the anchor slots
            queue_packet(CMD_RECORD, 1'b1, '1, (i == 0) ? '1 : $urandom, '1);
        queue_packet(CMD_QUERY,  1'b0, '1, '0, '0);
        queue_packet(CMD_RECORD, 1'b1, '0, $urandom, '0);
        for (int i = 0; i < 8; i++)                          // wraps into replacement
            queue_packet(CMD_RECORD, 1'b1, {$urandom, $urandom}, $urandom, 32'd10 + i);
        queue_packet(CMD_RECORD, 1'b1, key_pool[0], '0, 32'd3);
        queue_packet(CMD_QUERY,  1'b1, {$urandom, $urandom}, '1, '1);
        queue_packet(CMD_QUERY,  1'b1, key_pool[0], '0, '0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            program_min(phase_min[ph]);
            @(negedge clk);
            burst_mode = (ph == 5);
            if (ph == 3)
                stall_armed = 1'b1;
            for (int n = 0; n < PHASE_LEN; n++)
                queue_random_packet();
            wait_drained();
        end

        repeat (NENT + 8) @(posedge clk);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ktt_pkg.sv
rtl/core/ktt_ram.sv
rtl/core/keyed_timestamp_table_oldest_replace_core.sv
tb/keyed_timestamp_table_oldest_replace_core_tb.sv
